>>> src/osi_pkg.sv
// ----------------------------------------------------------------------------
// osi_pkg
// Types and codes used by the operand stack core.
// ----------------------------------------------------------------------------
package osi_pkg;

  // Fixed widths of the transfer fields
  localparam int OP_W    = 3;
  localparam int DATA_W  = 64;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 3;
  localparam int LEVEL_W = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_POP      = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OP_W-1:0] OP_SET      = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_CNT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_COUNT    = 3'd4;

  // Limit after reset
  localparam logic [LEVEL_W-1:0] MAX_DEPTH_RST = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } osi_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [STAT_W-1:0]  status;
    logic [LEVEL_W-1:0] depth;
  } osi_out_t;

endpackage

>>> src/osi_ram.sv
// ----------------------------------------------------------------------------
// osi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module osi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/operand_stack_indexed_core.sv
// ----------------------------------------------------------------------------
// operand_stack_indexed_core
// LIFO operand stack with push, pop, indexed peek and set, pop count, clear.
// ----------------------------------------------------------------------------
// One operation is taken in every clock cycle: busy stays low, so start may be
// held high for back-to-back operations. The result appears on out_result with
// out_valid in the cycle after the operation is taken; both come from registers,
// and popped and peeked words come from the registered read port of the entry
// RAM. The fill level, the checks and any RAM write are resolved in
// the cycle the operation is taken, so an operation always sees the effect of
// the one before it. Results cannot be stalled and must be captured in the
// cycle they are shown. Entries need no clearing after reset; only positions
// below the fill level are ever read. max_depth may be written through cfg_we
// and cfg_wdata while no operation is in progress.
module operand_stack_indexed_core #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  osi_pkg::osi_in_t               in_item,
  output logic                           out_valid,
  output osi_pkg::osi_out_t              out_result,
  input  logic                           cfg_we,
  input  logic [osi_pkg::LEVEL_W-1:0]    cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LVL_W > osi_pkg::LEVEL_W) ? LVL_W : osi_pkg::LEVEL_W;

  logic [LVL_W-1:0]            fill_r, fill_nxt;
  logic [osi_pkg::LEVEL_W-1:0] max_depth_r;
  logic                        out_valid_r;
  logic [osi_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic                        rd_sel_r, rd_sel_nxt;

  logic                        accept;
  logic [CMP_W-1:0]            fill_ext;
  logic [CMP_W-1:0]            idx_ext;
  logic [CMP_W-1:0]            slot;
  logic                        full;
  logic                        idx_bad;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_re;
  logic [WORD_WIDTH-1:0]       ram_rdata;

  // Every cycle can take an operation
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign fill_ext = CMP_W'(fill_r);
  // Pop reads the top, which is peek at position zero
  assign idx_ext  = (in_item.op == osi_pkg::OP_POP) ? '0 : CMP_W'(in_item.index);
  assign slot     = fill_ext - CMP_W'(1) - idx_ext;
  assign full     = (fill_ext >= CMP_W'(max_depth_r)) || (fill_ext >= CMP_W'(DEPTH));
  assign idx_bad  = CMP_W'(in_item.index) >= fill_ext;

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = osi_pkg::ST_OK;
    rd_sel_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = AW'(slot);
    case (in_item.op)
      osi_pkg::OP_PUSH: begin
        ram_waddr = AW'(fill_r);
        if (full) begin
          status_nxt = osi_pkg::ST_OVERFLOW;
        end else begin
          ram_we   = accept;
          fill_nxt = fill_r + LVL_W'(1);
        end
      end
      osi_pkg::OP_POP: begin
        if (fill_r == '0) begin
          status_nxt = osi_pkg::ST_EMPTY;
        end else begin
          ram_re     = accept;
          rd_sel_nxt = 1'b1;
          fill_nxt   = fill_r - LVL_W'(1);
        end
      end
      osi_pkg::OP_PEEK: begin
        if (idx_bad) begin
          status_nxt = osi_pkg::ST_RANGE;
        end else begin
          ram_re     = accept;
          rd_sel_nxt = 1'b1;
        end
      end
      osi_pkg::OP_SET: begin
        if (idx_bad) begin
          status_nxt = osi_pkg::ST_RANGE;
        end else begin
          ram_we = accept;
        end
      end
      osi_pkg::OP_POP_CNT: begin
        if (CMP_W'(in_item.count) > fill_ext) begin
          status_nxt = osi_pkg::ST_COUNT;
        end else begin
          fill_nxt = LVL_W'(fill_ext - CMP_W'(in_item.count));
        end
      end
      osi_pkg::OP_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
        // unused codes do nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      max_depth_r <= osi_pkg::MAX_DEPTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (cfg_we) begin
        max_depth_r <= cfg_wdata;
      end
    end
  end

  // Result fields, held until the next transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  osi_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.value[WORD_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (AW'(slot)),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_result.data   = rd_sel_r ? osi_pkg::DATA_W'(ram_rdata) : '0;
  assign out_result.status = status_r;
  assign out_result.depth  = osi_pkg::LEVEL_W'(fill_r);

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after a taken operation");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without a taken operation");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= CMP_W'(DEPTH))
    else $error("fill level above storage depth");

  a_error_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != osi_pkg::ST_OK) |-> fill_r == $past(fill_r))
    else $error("fill level changed by a failed operation");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != osi_pkg::ST_OK) |-> out_result.data == '0)
    else $error("data returned with an error status");
`endif

endmodule
